// File: hw/rtl/mpct_pkg.sv
// ----------------------------------------------------------------------------
// mpct_pkg
// Shared widths, codes, reset values and types of the mouse packet cursor
// tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mpct_pkg;

   localparam int BYTE_BITS          = 8;
   localparam int SIZE_BITS          = 13;   // screen size and cursor fields
   localparam int COORD_BITS_DEFAULT = 13;
   localparam int CSR_INDEX_BITS     = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLE        = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 2'd2;

   localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd768;

   // header byte layout
   localparam int                   SYNC_BIT      = 3;
   localparam logic [BYTE_BITS-1:0] OVERFLOW_MASK = 8'hC0;

   // a complete packet from the assembler
   typedef struct packed {
      logic                 keep;   // third byte of a packet without overflow
      logic [BYTE_BITS-1:0] dx;
      logic [BYTE_BITS-1:0] dy;
   } packet_type;

   // screen limits handed to the cursor update
   typedef struct packed {
      logic [SIZE_BITS-1:0] width;
      logic [SIZE_BITS-1:0] height;
   } screen_type;

endpackage

`default_nettype wire

// File: hw/rtl/mpct_req_if.sv
// ----------------------------------------------------------------------------
// mpct_req_if
// Byte channel into the tracker: valid, ready and one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpct_req_if;
   logic                           valid;
   logic                           ready;
   logic [mpct_pkg::BYTE_BITS-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mpct_rsp_if.sv
// ----------------------------------------------------------------------------
// mpct_rsp_if
// Cursor channel out of the tracker: valid, ready and the cursor position.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpct_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mpct_pkg::SIZE_BITS-1:0] cursor_x;
   logic [mpct_pkg::SIZE_BITS-1:0] cursor_y;

   modport source (output valid, output cursor_x, output cursor_y, input ready);
   modport sink   (input valid, input cursor_x, input cursor_y, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mpct_assembler.sv
// ----------------------------------------------------------------------------
// mpct_assembler
// Collects header, X and Y bytes into packets; drops headers without the
// sync bit.
// ----------------------------------------------------------------------------
`default_nettype none

module mpct_assembler (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           byte_take,   // accepted and enabled
   input  wire logic [mpct_pkg::BYTE_BITS-1:0] byte_data,
   output mpct_pkg::packet_type                packet
);

   localparam logic [1:0] IDX_HEADER = 2'd0;
   localparam logic [1:0] IDX_X      = 2'd1;
   localparam logic [1:0] IDX_Y      = 2'd2;

   logic [1:0]                     idx_ff, idx_in;
   logic [mpct_pkg::BYTE_BITS-1:0] hdr_ff, hdr_in;
   logic [mpct_pkg::BYTE_BITS-1:0] xd_ff, xd_in;

   always_comb begin
      idx_in = idx_ff;
      hdr_in = hdr_ff;
      xd_in  = xd_ff;
      if (byte_take) begin
         case (idx_ff)
            IDX_HEADER: begin
               if (byte_data[mpct_pkg::SYNC_BIT]) begin
                  hdr_in = byte_data;
                  idx_in = IDX_X;
               end
            end
            IDX_X: begin
               xd_in  = byte_data;
               idx_in = IDX_Y;
            end
            default: begin
               idx_in = IDX_HEADER;
            end
         endcase
      end
   end

   always_comb begin
      packet.keep = byte_take && (idx_ff == IDX_Y)
                    && ((hdr_ff & mpct_pkg::OVERFLOW_MASK) == '0);
      packet.dx   = xd_ff;
      packet.dy   = byte_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= IDX_HEADER;
      end else begin
         idx_ff <= idx_in;
      end
      hdr_ff <= hdr_in;
      xd_ff  <= xd_in;
   end

   // index only walks header -> X -> Y
   a_idx_legal: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd3) else $error("byte index out of range");

   a_idx_hold: assert property (@(posedge clock) disable iff (reset)
      !byte_take |=> $stable(idx_ff)) else $error("index moved without a byte");

   a_keep_after_x: assert property (@(posedge clock) disable iff (reset)
      packet.keep |-> $past(idx_ff) == IDX_X || $past(idx_ff) == IDX_Y)
      else $error("packet kept out of sequence");

endmodule

`default_nettype wire

// File: hw/rtl/mpct_cursor.sv
// ----------------------------------------------------------------------------
// mpct_cursor
// Holds the cursor position and applies clamped packet deltas.
// ----------------------------------------------------------------------------
`default_nettype none

module mpct_cursor #(
   parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire mpct_pkg::packet_type           packet,
   input  wire mpct_pkg::screen_type           screen,
   output logic                                moved,     // kept packet, nonzero delta
   output logic [mpct_pkg::SIZE_BITS-1:0]      next_x,
   output logic [mpct_pkg::SIZE_BITS-1:0]      next_y
);

   localparam int SB = mpct_pkg::SIZE_BITS;
   localparam int BB = mpct_pkg::BYTE_BITS;
   // wide enough for position, limit and sign
   localparam int W  = ((COORD_BITS > SB) ? COORD_BITS : SB) + 2;

   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;

   function automatic logic [COORD_BITS-1:0] clamp(
      input logic signed [W-1:0] v,
      input logic [SB-1:0]       size
   );
      logic [W-1:0] lim;
      logic [W-1:0] cap;
      begin
         lim = (size == '0) ? '0 : {{(W-SB){1'b0}}, size - 1'b1};
         cap = {{(W-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
         if (lim > cap) lim = cap;
         if (v < 0)
            clamp = '0;
         else if ($unsigned(v) > lim)
            clamp = lim[COORD_BITS-1:0];
         else
            clamp = v[COORD_BITS-1:0];
      end
   endfunction

   logic signed [W-1:0] sum_x, sum_y;

   always_comb begin
      sum_x = $signed({{(W-COORD_BITS){1'b0}}, pos_x_ff})
            + $signed({{(W-BB){packet.dx[BB-1]}}, packet.dx});
      sum_y = $signed({{(W-COORD_BITS){1'b0}}, pos_y_ff})
            - $signed({{(W-BB){packet.dy[BB-1]}}, packet.dy});
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (packet.keep) begin
         pos_x_in = clamp(sum_x, screen.width);
         pos_y_in = clamp(sum_y, screen.height);
      end
      moved  = packet.keep && ((packet.dx != '0) || (packet.dy != '0));
      next_x = SB'(pos_x_in);
      next_y = SB'(pos_y_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !packet.keep |=> $stable(pos_x_ff) && $stable(pos_y_ff))
      else $error("cursor moved without a packet");

   a_x_in_screen: assert property (@(posedge clock) disable iff (reset)
      packet.keep && screen.width != '0 |=>
         {{(W-COORD_BITS){1'b0}}, pos_x_ff} < {{(W-SB){1'b0}}, $past(screen.width)})
      else $error("cursor x past screen edge");

   a_y_in_screen: assert property (@(posedge clock) disable iff (reset)
      packet.keep && screen.height != '0 |=>
         {{(W-COORD_BITS){1'b0}}, pos_y_ff} < {{(W-SB){1'b0}}, $past(screen.height)})
      else $error("cursor y past screen edge");

endmodule

`default_nettype wire

// File: hw/rtl/mouse_packet_cursor_tracker.sv
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker
// Assembles three-byte mouse packets and tracks a clamped screen cursor.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          payload
//   req      in   valid / ready      rx_byte[7:0]
//   rsp      out  valid / ready      cursor_x[12:0], cursor_y[12:0]
//   csr      in   csr_we             csr_index[1:0], csr_wdata[12:0]
//
// One byte per cycle. A byte is taken in the cycle it is offered while
// req.ready is high; the third byte of a moving packet puts the cursor in the
// output register in the next cycle. The output register is the only stall
// point: req.ready drops only while a cursor item waits and rsp.ready is low.
// Disabled bytes drop. Synchronous reset clears packet index, cursor, enable.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_packet_cursor_tracker #(
   parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   mpct_req_if.sink                                 req,
   mpct_rsp_if.source                               rsp,
   input  wire logic                                csr_we,
   input  wire logic [mpct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mpct_pkg::SIZE_BITS-1:0]      csr_wdata
);

   localparam int SB = mpct_pkg::SIZE_BITS;

   // configuration
   logic                 enable_ff;
   logic [SB-1:0]        width_ff;
   logic [SB-1:0]        height_ff;
   mpct_pkg::screen_type screen;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]        rsp_x_ff, rsp_y_ff;

   logic                 take;        // byte accepted this cycle
   mpct_pkg::packet_type packet;
   logic                 moved;
   logic [SB-1:0]        next_x, next_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         width_ff  <= mpct_pkg::SCREEN_WIDTH_RESET;
         height_ff <= mpct_pkg::SCREEN_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mpct_pkg::CSR_ENABLE:        enable_ff <= csr_wdata[0];
            mpct_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            mpct_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: begin
               // unmapped index: no register
            end
         endcase
      end
   end

   assign screen.width  = width_ff;
   assign screen.height = height_ff;

   // new byte fits whenever the output slot is free or draining
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign take      = req.valid && req.ready && enable_ff;

   mpct_assembler u_assembler (
      .clock     (clock),
      .reset     (reset),
      .byte_take (take),
      .byte_data (req.rx_byte),
      .packet    (packet)
   );

   mpct_cursor #(
      .COORD_BITS (COORD_BITS)
   ) u_cursor (
      .clock  (clock),
      .reset  (reset),
      .packet (packet),
      .screen (screen),
      .moved  (moved),
      .next_x (next_x),
      .next_y (next_y)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (moved) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (moved) begin
         rsp_x_ff <= next_x;
         rsp_y_ff <= next_y;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.cursor_x = rsp_x_ff;
   assign rsp.cursor_y = rsp_y_ff;

   // a waiting item is never overwritten by a new one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !moved) else $error("cursor item overwritten");

   // stall only while an item waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp_valid_ff) else $error("input stalled with empty output");

   // a fresh item follows an accepted, enabled byte
   a_item_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(take)) else $error("item without a byte");

   // disabled bytes leave the cursor output alone
   a_disabled_quiet: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && !enable_ff |=> $stable(rsp_x_ff) && $stable(rsp_y_ff))
      else $error("disabled byte changed the cursor");

endmodule

`default_nettype wire
